// ----- hdl/bdpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bdpe_pkg
// Shared types and constants for the button debounce and press event block.
// ----------------------------------------------------------------------------
package bdpe_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST   = 16'd15;
  localparam logic [CFG_DATA_W-1:0] SHORT_PRESS_MAX_RST  = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TICKS_RST = 16'd3000;

  // pin and stable levels are active low
  localparam logic LEVEL_RELEASED = 1'b1;
  localparam logic LEVEL_PRESSED  = 1'b0;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ticks;
    logic [CFG_DATA_W-1:0] short_press_max;
    logic [CFG_DATA_W-1:0] long_press_ticks;
  } bdpe_cfg_t;

  typedef struct packed {
    logic stable_out;
    logic press_event;
    logic short_press_event;
    logic release_event;
    logic long_press_event;
  } bdpe_result_t;

endpackage

// ----- hdl/bdpe_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bdpe_cfg_regs
// Threshold registers written through the configuration port.
// ----------------------------------------------------------------------------
module bdpe_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [bdpe_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [bdpe_pkg::CFG_DATA_W-1:0]      wr_data,
  output bdpe_pkg::bdpe_cfg_t                  cfg
);

  bdpe_pkg::bdpe_cfg_t cfg_r;
  bdpe_pkg::bdpe_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        bdpe_pkg::REG_DEBOUNCE_TICKS:   cfg_nxt.debounce_ticks   = wr_data;
        bdpe_pkg::REG_SHORT_PRESS_MAX:  cfg_nxt.short_press_max  = wr_data;
        bdpe_pkg::REG_LONG_PRESS_TICKS: cfg_nxt.long_press_ticks = wr_data;
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bdpe_pkg::DEBOUNCE_TICKS_RST;
      cfg_r.short_press_max  <= bdpe_pkg::SHORT_PRESS_MAX_RST;
      cfg_r.long_press_ticks <= bdpe_pkg::LONG_PRESS_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/bdpe_core.sv -----
// ----------------------------------------------------------------------------
// bdpe_core
// Per-tick debounce state update and press event decode.
// ----------------------------------------------------------------------------
module bdpe_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   pin_level,
  input  bdpe_pkg::bdpe_cfg_t    cfg,
  output bdpe_pkg::bdpe_result_t result
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > bdpe_pkg::CFG_DATA_W) ? COUNT_WIDTH : bdpe_pkg::CFG_DATA_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   raw_last_r,     raw_last_nxt;
  logic                   settling_r,     settling_nxt;
  logic [COUNT_WIDTH-1:0] settle_count_r, settle_count_nxt;
  logic                   stable_r,       stable_nxt;
  logic                   long_armed_r,   long_armed_nxt;
  logic [COUNT_WIDTH-1:0] press_count_r,  press_count_nxt;

  logic [CMP_W-1:0] settle_cmp;
  logic [CMP_W-1:0] press_cmp;

  always_comb begin
    raw_last_nxt     = raw_last_r;
    settling_nxt     = settling_r;
    settle_count_nxt = settle_count_r;
    stable_nxt       = stable_r;
    long_armed_nxt   = long_armed_r;
    result           = '0;

    // raw change restarts the settle counter
    if (pin_level != raw_last_r) begin
      raw_last_nxt     = pin_level;
      settling_nxt     = 1'b1;
      settle_count_nxt = '0;
    end else if (settling_r && settle_count_r != CNT_MAX) begin
      settle_count_nxt = settle_count_r + 1'b1;
    end

    settle_cmp = CMP_W'(settle_count_nxt);
    if (settling_nxt && settle_cmp >= CMP_W'(cfg.debounce_ticks)) begin
      stable_nxt   = raw_last_nxt;
      settling_nxt = 1'b0;
    end

    press_count_nxt = (press_count_r == CNT_MAX) ? CNT_MAX : press_count_r + 1'b1;

    if (stable_nxt != stable_r) begin
      if (stable_nxt == bdpe_pkg::LEVEL_PRESSED) begin
        result.press_event = 1'b1;
        long_armed_nxt     = 1'b1;
        press_count_nxt    = '0;
      end else begin
        result.short_press_event =
          (CMP_W'(press_count_nxt) <= CMP_W'(cfg.short_press_max));
        result.release_event = 1'b1;
        long_armed_nxt       = 1'b0;
      end
    end

    press_cmp = CMP_W'(press_count_nxt);
    if (long_armed_nxt && press_cmp >= CMP_W'(cfg.long_press_ticks)) begin
      result.long_press_event = 1'b1;
      long_armed_nxt          = 1'b0;
    end

    result.stable_out = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r     <= bdpe_pkg::LEVEL_RELEASED;
      settling_r     <= 1'b0;
      settle_count_r <= '0;
      stable_r       <= bdpe_pkg::LEVEL_RELEASED;
      long_armed_r   <= 1'b0;
      press_count_r  <= '0;
    end else if (step) begin
      raw_last_r     <= raw_last_nxt;
      settling_r     <= settling_nxt;
      settle_count_r <= settle_count_nxt;
      stable_r       <= stable_nxt;
      long_armed_r   <= long_armed_nxt;
      press_count_r  <= press_count_nxt;
    end
  end

endmodule

// ----- hdl/bdpe_out_buf.sv -----
// ----------------------------------------------------------------------------
// bdpe_out_buf
// Result register with one skid entry, full rate under a registered stall.
// ----------------------------------------------------------------------------
module bdpe_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bdpe_pkg::bdpe_result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bdpe_pkg::bdpe_result_t out_data
);

  logic                   out_valid_r,  out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  bdpe_pkg::bdpe_result_t out_data_r,   out_data_nxt;
  bdpe_pkg::bdpe_result_t skid_data_r,  skid_data_nxt;
  logic                   pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end else if (push) begin
      // receiver stalled, park the word
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/button_debounce_press_events.sv -----
// ----------------------------------------------------------------------------
// button_debounce_press_events
// Push button debouncer with press, release, short-press and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per tick carrying the raw active-low pin sample; taken
//           when in_valid is high and in_stall is low.
//   out_* : one word per input word: debounced level and four event flags;
//           taken when out_valid is high and out_stall is low.
//   cfg_* : register writes (debounce ticks, short press limit, long press
//           ticks), taken when cfg_valid and cfg_ready are high; cfg_ready
//           is always high. Write only while the block is idle.
// The result word is computed from the debounce state and registered in the
// output buffer; throughput is one word per cycle while out_stall is low.
// A stalled receiver first fills a one-word skid entry, then in_stall rises;
// no word is lost or repeated. Reset returns the thresholds to 15, 1000 and
// 3000, clears both counters and sets the debounced level to released, so
// no press is reported at start-up.
// ----------------------------------------------------------------------------
module button_debounce_press_events #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_pin_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_stable_out,
  output logic                                out_press_event,
  output logic                                out_short_press_event,
  output logic                                out_release_event,
  output logic                                out_long_press_event,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bdpe_pkg::bdpe_cfg_t    cfg;
  bdpe_pkg::bdpe_result_t step_result;
  bdpe_pkg::bdpe_result_t out_word;
  logic                   buf_full;
  logic                   in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  bdpe_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bdpe_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_accept),
    .pin_level (in_pin_level),
    .cfg       (cfg),
    .result    (step_result)
  );

  bdpe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_word)
  );

  assign out_stable_out        = out_word.stable_out;
  assign out_press_event       = out_word.press_event;
  assign out_short_press_event = out_word.short_press_event;
  assign out_release_event     = out_word.release_event;
  assign out_long_press_event  = out_word.long_press_event;

endmodule
